// File: hdl/lrud_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrud_pkg
// Shared widths, command codes and the line write bundle of the LRU
// tag directory.
// ----------------------------------------------------------------------------
package lrud_pkg;

  localparam int KEY_W     = 64;
  localparam int LEN_W     = 17;
  localparam int IDX_OUT_W = 3;

  // request commands
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_SAVE   = 1'b1;

  // write bundle from the controller to one line cell
  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] length;
  } line_wr_t;

endpackage
`default_nettype wire

// File: hdl/lru_tag_cache_directory.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_tag_cache_directory
// Fully associative cache directory with exact LRU order.
// ----------------------------------------------------------------------------
// Each request has a compare step, the parallel key compare in the line
// cells, and an update step, where the recency list shifts along its chain
// of position cells, a save writes the tail line and the result is loaded
// into the output register. The update waits while that register holds a
// stalled result; a new request is taken as the update completes, never
// during a compare. A lookup takes the lowest-indexed matching line and
// moves it to the front; a save always replaces the least recently used
// line. Lengths above MAX_OBJECT are saturated. There is no clearing pass
// after reset; line valid marks reset to zero at once.
// ----------------------------------------------------------------------------
module lru_tag_cache_directory #(
  parameter int LINES      = 8,
  parameter int MAX_OBJECT = 102400
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                command,
  input  wire logic [lrud_pkg::KEY_W-1:0]          key,
  input  wire logic [lrud_pkg::LEN_W-1:0]          object_length,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     hit,
  output logic      [lrud_pkg::IDX_OUT_W-1:0]      line_index,
  output logic      [lrud_pkg::LEN_W-1:0]          stored_length
);

  localparam int IDX_W   = $clog2(LINES);
  localparam int SAT_W   = 21;
  localparam logic [SAT_W-1:0] MAX_LEN = SAT_W'(MAX_OBJECT);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic                       req_cmd;
  logic [lrud_pkg::KEY_W-1:0] req_key;
  logic [lrud_pkg::LEN_W-1:0] req_len;

  logic                       can_load;
  logic                       accept;
  logic                       upd_go;
  logic                       is_save;
  logic                       move_en;
  logic [SAT_W-1:0]           len_ext;
  logic [lrud_pkg::LEN_W-1:0] len_sat;

  logic [LINES-1:0]           line_match;
  logic [lrud_pkg::LEN_W-1:0] line_len [LINES];
  logic [LINES-1:0]           first_hit;
  logic                       any_hit;
  logic [IDX_W-1:0]           hit_idx;
  logic [lrud_pkg::LEN_W-1:0] hit_len;

  logic [IDX_W-1:0]           order_val [LINES];
  logic [LINES-1:0]           seen;
  logic [IDX_W-1:0]           victim;
  logic [IDX_W-1:0]           target;
  logic [IDX_W+2:0]           target_ext;

  // input and output handshake
  assign can_load = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) || ((state == ST_UPD) && can_load));
  assign accept   = in_valid && !in_stall;
  assign upd_go   = (state == ST_UPD) && can_load;

  // request sequencing
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (can_load) state_next = accept ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // length saturation on the incoming transfer
  assign len_ext = {{(SAT_W-lrud_pkg::LEN_W){1'b0}}, object_length};
  assign len_sat = (len_ext > MAX_LEN) ? MAX_LEN[lrud_pkg::LEN_W-1:0] : object_length;

  // request registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd <= command;
      req_key <= key;
      req_len <= len_sat;
    end
  end

  assign is_save = (req_cmd == lrud_pkg::CMD_SAVE);

  // line cells
  for (genvar i = 0; i < LINES; i++) begin : g_line
    lrud_pkg::line_wr_t wr;

    assign wr = {upd_go && is_save && (victim == IDX_W'(i)), req_key, req_len};

    lrud_line_cell u_line (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr),
      .cmp_en  (state == ST_CMP),
      .cmp_key (req_key),
      .match   (line_match[i]),
      .length  (line_len[i])
    );
  end

  // lowest-indexed match
  assign first_hit = line_match & (~line_match + LINES'(1));
  assign any_hit   = |line_match;

  always_comb begin
    hit_idx = '0;
    hit_len = '0;
    for (int i = 0; i < LINES; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_len = hit_len | line_len[i];
      end
    end
  end

  // line to move to the front of the recency list
  assign victim  = order_val[LINES-1];
  assign target  = is_save ? victim : hit_idx;
  assign move_en = upd_go && (is_save || any_hit);

  // recency chain, position 0 most recent
  for (genvar p = 0; p < LINES; p++) begin : g_order
    logic [IDX_W-1:0] prev_value;
    logic             seen_in;

    if (p == 0) begin : g_front
      assign prev_value = target;
    end else begin : g_body
      assign prev_value = order_val[p-1];
    end

    if (p == LINES-1) begin : g_tail
      assign seen_in = 1'b0;
    end else begin : g_inner
      assign seen_in = seen[p+1];
    end

    lrud_order_cell #(
      .IDX_W (IDX_W),
      .POS   (p)
    ) u_order (
      .clk        (clk),
      .rst        (rst),
      .move_en    (move_en),
      .target     (target),
      .prev_value (prev_value),
      .seen_in    (seen_in),
      .value      (order_val[p]),
      .seen_out   (seen[p])
    );
  end

  // result register
  assign target_ext = {3'b000, target};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      hit           <= !is_save && any_hit;
      line_index    <= target_ext[lrud_pkg::IDX_OUT_W-1:0];
      stored_length <= is_save ? req_len : hit_len;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lrud_line_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrud_line_cell
// One directory line: holds key, length and valid mark, and compares its
// key against the pending request key.
// ----------------------------------------------------------------------------
module lrud_line_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lrud_pkg::line_wr_t            wr,
  input  wire logic                          cmp_en,
  input  wire logic [lrud_pkg::KEY_W-1:0]    cmp_key,
  output logic                               match,
  output logic      [lrud_pkg::LEN_W-1:0]    length
);

  logic [lrud_pkg::KEY_W-1:0] key;
  logic                       valid;

  // line contents
  always_ff @(posedge clk) begin
    if (wr.en) begin
      key    <= wr.key;
      length <= wr.length;
    end
  end

  // valid mark
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en) begin
      valid <= 1'b1;
    end
  end

  // registered tag compare
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (cmp_en) begin
      match <= valid && (key == cmp_key);
    end
  end

endmodule
`default_nettype wire

// File: hdl/lrud_order_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrud_order_cell
// One position of the recency list. Holds a line number; on a move it takes
// its front neighbor's value when the moved line sits here or further back.
// ----------------------------------------------------------------------------
module lrud_order_cell #(
  parameter int IDX_W = 3,
  parameter int POS   = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             move_en,
  input  wire logic [IDX_W-1:0] target,
  input  wire logic [IDX_W-1:0] prev_value,
  input  wire logic             seen_in,
  output logic      [IDX_W-1:0] value,
  output logic                  seen_out
);

  // target found here or behind this position
  assign seen_out = (value == target) || seen_in;

  // shift toward the tail
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= IDX_W'(POS);
    end else if (move_en && seen_out) begin
      value <= prev_value;
    end
  end

endmodule
`default_nettype wire

// File: tb/lru_tag_cache_directory_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_tag_cache_directory_test
// Self-checking bench for the LRU tag directory. A short table of directed
// requests covers misses, saves with and without saturation, hits, duplicate
// keys and the all-zero and all-one keys. A long random run follows, in
// which keys come mostly from a small pool so that hits and evictions are
// frequent. Untyped results are checked against an in-bench directory model
// that keeps its own keys, lengths, valid marks and recency list.
// ----------------------------------------------------------------------------
module lru_tag_cache_directory_test;

  localparam int DIR_LINES       = 8;
  localparam int MAX_LEN         = 102400;
  localparam int RANDOM_REQUESTS = 1500;
  localparam int STALL_PCT       = 23;
  localparam int HOLD_CYCLES     = 120;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int POOL_SIZE       = 12;
  localparam int N_DIRECTED      = 21;

  typedef struct packed {
    logic                           hit;
    logic [lrud_pkg::IDX_OUT_W-1:0] line_index;
    logic [lrud_pkg::LEN_W-1:0]     stored_length;
  } dir_result_t;

  typedef struct {
    logic                       command;
    logic [lrud_pkg::KEY_W-1:0] key;
    logic [lrud_pkg::LEN_W-1:0] length;
    bit                         fixed;
    dir_result_t                want;
  } dir_row_t;

  localparam dir_result_t NO_WANT = '0;

  // directed requests; typed results only where obvious
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{lrud_pkg::CMD_LOOKUP, 64'h0000_0000_0000_0000, 17'd0,      1'b1, {1'b0, 3'd0, 17'd0}},
    '{lrud_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 17'h1FFFF,  1'b1, {1'b0, 3'd0, 17'd0}},
    '{lrud_pkg::CMD_SAVE,   64'h0000_0000_0000_0000, 17'd0,      1'b1, {1'b0, 3'd7, 17'd0}},
    '{lrud_pkg::CMD_SAVE,   64'hFFFF_FFFF_FFFF_FFFF, 17'd102400, 1'b1,
      {1'b0, 3'd6, 17'd102400}},
    '{lrud_pkg::CMD_SAVE,   64'h5555_5555_5555_5555, 17'h1FFFF,  1'b1,
      {1'b0, 3'd5, 17'd102400}},
    '{lrud_pkg::CMD_SAVE,   64'hAAAA_AAAA_AAAA_AAAA, 17'd102401, 1'b1,
      {1'b0, 3'd4, 17'd102400}},
    '{lrud_pkg::CMD_LOOKUP, 64'h0000_0000_0000_0000, 17'd5,      1'b1, {1'b1, 3'd7, 17'd0}},
    '{lrud_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 17'd0,      1'b1,
      {1'b1, 3'd6, 17'd102400}},
    '{lrud_pkg::CMD_SAVE,   64'h0000_0000_0000_0000, 17'd100,    1'b0, NO_WANT},
    '{lrud_pkg::CMD_LOOKUP, 64'h0000_0000_0000_0000, 17'd0,      1'b0, NO_WANT},
    '{lrud_pkg::CMD_LOOKUP, 64'h0000_0000_0000_0001, 17'd0,      1'b1, {1'b0, 3'd0, 17'd0}},
    '{lrud_pkg::CMD_SAVE,   64'h0123_4567_89AB_CDEF, 17'd1,      1'b0, NO_WANT},
    '{lrud_pkg::CMD_SAVE,   64'hFEDC_BA98_7654_3210, 17'h10000,  1'b0, NO_WANT},
    '{lrud_pkg::CMD_SAVE,   64'h8000_0000_0000_0001, 17'd102399, 1'b0, NO_WANT},
    '{lrud_pkg::CMD_LOOKUP, 64'h5555_5555_5555_5555, 17'd0,      1'b0, NO_WANT},
    '{lrud_pkg::CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 17'd0,      1'b0, NO_WANT},
    '{lrud_pkg::CMD_SAVE,   64'h7FFF_FFFF_FFFF_FFFF, 17'h0FFFF,  1'b0, NO_WANT},
    '{lrud_pkg::CMD_SAVE,   64'h0000_0000_0000_0000, 17'd12345,  1'b0, NO_WANT},
    '{lrud_pkg::CMD_LOOKUP, 64'h0000_0000_0000_0000, 17'd0,      1'b0, NO_WANT},
    '{lrud_pkg::CMD_LOOKUP, 64'h0123_4567_89AB_CDEF, 17'd0,      1'b0, NO_WANT},
    '{lrud_pkg::CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 17'd0,      1'b0, NO_WANT}
  };

  logic                           clk           = 1'b0;
  logic                           rst           = 1'b1;
  logic                           in_valid      = 1'b0;
  logic                           in_stall;
  logic                           command       = lrud_pkg::CMD_LOOKUP;
  logic [lrud_pkg::KEY_W-1:0]     key           = '0;
  logic [lrud_pkg::LEN_W-1:0]     object_length = '0;
  logic                           out_valid;
  logic                           out_stall     = 1'b0;
  logic                           hit;
  logic [lrud_pkg::IDX_OUT_W-1:0] line_index;
  logic [lrud_pkg::LEN_W-1:0]     stored_length;

  // typed expectation riding along with the current request
  bit          tx_fixed = 1'b0;
  dir_result_t tx_want  = '0;

  // traffic shaping
  bit quiet_mode = 1'b0;
  bit hold_req   = 1'b0;

  // directory model state
  logic [lrud_pkg::KEY_W-1:0] model_keys    [DIR_LINES];
  logic [lrud_pkg::LEN_W-1:0] model_lengths [DIR_LINES];
  bit                         model_valid   [DIR_LINES];
  int                         recency_list  [DIR_LINES];

  dir_result_t results_due [$];
  int          fail_count   = 0;
  int          stuck_cycles = 0;
  logic [lrud_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  lru_tag_cache_directory #(
    .LINES     (DIR_LINES),
    .MAX_OBJECT(MAX_LEN)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .key          (key),
    .object_length(object_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .line_index   (line_index),
    .stored_length(stored_length)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // move a line to the most recent position
  function automatic void promote_line(input int line);
    int pos;
    pos = 0;
    for (int p = 0; p < DIR_LINES; p++) begin
      if (recency_list[p] == line) begin
        pos = p;
        break;
      end
    end
    for (int p = pos; p > 0; p--) recency_list[p] = recency_list[p-1];
    recency_list[0] = line;
  endfunction

  // one directory request: returns the result and updates the model
  function automatic dir_result_t directory_access(
      input logic cmd,
      input logic [lrud_pkg::KEY_W-1:0] k,
      input logic [lrud_pkg::LEN_W-1:0] len);
    dir_result_t r;
    int          victim;
    logic [lrud_pkg::LEN_W-1:0] sat_len;
    r = '0;
    if (cmd == lrud_pkg::CMD_LOOKUP) begin
      for (int i = 0; i < DIR_LINES; i++) begin
        if (model_valid[i] && model_keys[i] == k) begin
          r.hit           = 1'b1;
          r.line_index    = lrud_pkg::IDX_OUT_W'(i);
          r.stored_length = model_lengths[i];
          promote_line(i);
          break;
        end
      end
    end else begin
      victim  = recency_list[DIR_LINES-1];
      sat_len = (len > lrud_pkg::LEN_W'(MAX_LEN)) ? lrud_pkg::LEN_W'(MAX_LEN) : len;
      model_keys[victim]    = k;
      model_lengths[victim] = sat_len;
      model_valid[victim]   = 1'b1;
      promote_line(victim);
      r.line_index    = lrud_pkg::IDX_OUT_W'(victim);
      r.stored_length = sat_len;
    end
    return r;
  endfunction

  // request side: random gaps, then hold until the transfer happens
  task automatic send_request(input logic cmd, input logic [lrud_pkg::KEY_W-1:0] k,
                              input logic [lrud_pkg::LEN_W-1:0] len, input bit fixed,
                              input dir_result_t want);
    while (!quiet_mode && $urandom_range(99) < STALL_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    command       = cmd;
    key           = k;
    object_length = len;
    tx_fixed      = fixed;
    tx_want       = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // result side backpressure, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall = !quiet_mode && ($urandom_range(99) < STALL_PCT);
    end
  end

  // model update on request transfers, check on result transfers
  always @(posedge clk) begin
    dir_result_t seen;
    dir_result_t want;
    if (rst) begin
      for (int i = 0; i < DIR_LINES; i++) begin
        model_valid[i]  = 1'b0;
        recency_list[i] = i;
      end
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = {hit, line_index, stored_length};
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result %0h with nothing outstanding", seen));
        end else begin
          want = results_due.pop_front();
          if (seen.hit !== want.hit)
            report_mismatch($sformatf("hit got %0b expected %0b", seen.hit, want.hit));
          if (seen.line_index !== want.line_index)
            report_mismatch($sformatf("line_index got %0d expected %0d",
                                      seen.line_index, want.line_index));
          if (seen.stored_length !== want.stored_length)
            report_mismatch($sformatf("stored_length got %0d expected %0d",
                                      seen.stored_length, want.stored_length));
        end
      end
      if (in_valid && !in_stall) begin
        want = directory_access(command, key, object_length);
        if (tx_fixed) want = tx_want;
        results_due.push_back(want);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("lru_tag_cache_directory_test NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // stimulus
  initial begin
    logic                       cmd;
    logic [lrud_pkg::KEY_W-1:0] k;
    logic [lrud_pkg::LEN_W-1:0] len;
    int                         pick;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (directed_rows[r])
      send_request(directed_rows[r].command, directed_rows[r].key,
                   directed_rows[r].length, directed_rows[r].fixed,
                   directed_rows[r].want);

    // random traffic over a small key pool
    foreach (key_pool[p]) key_pool[p] = {$urandom, $urandom};
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      quiet_mode = (n >= 300 && n < 600);
      if (n == 900) hold_req = 1'b1;
      cmd  = ($urandom_range(1) == 1) ? lrud_pkg::CMD_SAVE : lrud_pkg::CMD_LOOKUP;
      pick = $urandom_range(99);
      if (pick < 75) begin
        k = key_pool[$urandom_range(POOL_SIZE-1)];
      end else begin
        k = {$urandom, $urandom};
        if (cmd == lrud_pkg::CMD_SAVE) key_pool[$urandom_range(POOL_SIZE-1)] = k;
      end
      pick = $urandom_range(99);
      if (pick < 85)      len = lrud_pkg::LEN_W'($urandom_range(MAX_LEN));
      else if (pick < 90) len = lrud_pkg::LEN_W'(MAX_LEN);
      else                len = lrud_pkg::LEN_W'($urandom);
      send_request(cmd, k, len, 1'b0, NO_WANT);
    end
    in_valid   = 1'b0;
    quiet_mode = 1'b0;

    // drain
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("lru_tag_cache_directory_test OK");
    else
      $display("lru_tag_cache_directory_test NOT OK");
    $finish;
  end

endmodule
